// File: src/ppe_pkg.sv
// Shared types, codes and constants for the PNG palette extractor.
// No dependencies; every other file of the block refers to it by scoped names.
package ppe_pkg;

  // Palette size limit and widths that follow from it
  localparam int PALETTE_ENTRIES = 256;
  localparam int COUNT_W         = 9;

  // Chunk framing, in bytes
  localparam int CHUNK_FRAME  = 12;
  localparam int CHUNK_HEADER = 8;
  localparam int TYPE_LENGTH  = 4;
  localparam int SIG_LENGTH   = 8;

  // Parse phases
  localparam logic [2:0] PH_SIGNATURE = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_SKIP      = 3'd2;
  localparam logic [2:0] PH_PALETTE   = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_ENTRY      = 2'd0;
  localparam logic [1:0] KIND_COMPLETE   = 2'd1;
  localparam logic [1:0] KIND_NOT_PNG    = 2'd2;
  localparam logic [1:0] KIND_NO_PALETTE = 2'd3;

  // Chunk type tags
  localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

  // Result queue geometry; depth is a power of two so the pointers wrap on their own
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COUNT_W-1:0] count;
    logic               last;
  } ppe_result_t;

  // Up to two results written to the queue in one cycle
  typedef struct packed {
    logic [1:0]  num;
    ppe_result_t first;
    ppe_result_t second;
  } ppe_push_t;

  // PNG signature byte at a given position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

  // Floor of x/3 for x below 768: multiply by 683/2048
  function automatic logic [COUNT_W-1:0] third_of(input logic [9:0] x);
    logic [19:0] prod;
    prod = x * 10'd683;
    return prod[19:11];
  endfunction

endpackage

// File: src/ppe_parser.sv
// Chunk walker for the PNG palette extractor: per-byte parse state and result build.
// Depends on ppe_pkg; feeds up to two results per byte to ppe_result_fifo.
module ppe_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  input  logic [31:0]        file_length,
  output ppe_pkg::ppe_push_t push
);

  logic [31:0] byte_position, byte_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [32:0] next_chunk_offset, next_chunk_offset_next;
  logic [63:0] header_shift, header_shift_next;
  logic [ppe_pkg::COUNT_W-1:0] entries_used, entries_used_next;
  logic [1:0]  triple_phase, triple_phase_next;
  logic [7:0]  red_latch, red_latch_next;
  logic [7:0]  green_latch, green_latch_next;
  logic [ppe_pkg::COUNT_W-1:0] entry_counter, entry_counter_next;

  logic [63:0] header_shifted;
  logic [31:0] chunk_len;
  logic [31:0] chunk_type;
  logic [34:0] body_end;
  logic        overrun;
  logic        skip_short;
  logic        header_last;
  logic        skip_last;
  logic        sig_ok;
  logic [ppe_pkg::COUNT_W-1:0] quotient;
  logic [ppe_pkg::COUNT_W-1:0] counter_inc;
  logic [1:0]  num;
  ppe_pkg::ppe_result_t res_a, res_b, extra;

  // Header decode and the chunk bound checks
  assign header_shifted = {header_shift[55:0], data_byte};
  assign chunk_len      = header_shifted[63:32];
  assign chunk_type     = header_shifted[31:0];
  assign body_end       = {2'b0, next_chunk_offset} + {3'b0, chunk_len}
                          + 35'(ppe_pkg::CHUNK_HEADER + ppe_pkg::TYPE_LENGTH);
  assign overrun        = body_end > {3'b0, file_length};
  assign skip_short     = (body_end + 35'(ppe_pkg::CHUNK_FRAME)) > {3'b0, file_length};
  assign header_last    = {2'b0, byte_position} ==
                          ({1'b0, next_chunk_offset} + 34'(ppe_pkg::CHUNK_HEADER - 1));
  assign skip_last      = ({1'b0, byte_position} + 33'd1) == next_chunk_offset;
  assign sig_ok         = (file_length >= 32'(ppe_pkg::SIG_LENGTH)) &&
                          (data_byte == ppe_pkg::magic_byte(byte_position[2:0]));
  assign quotient       = (chunk_len >= 32'(3 * ppe_pkg::PALETTE_ENTRIES)) ?
                          ppe_pkg::COUNT_W'(ppe_pkg::PALETTE_ENTRIES) :
                          ppe_pkg::third_of(chunk_len[9:0]);
  assign counter_inc    = entry_counter + 1'b1;

  // Advance the parse by one byte and collect its results
  always_comb begin
    byte_position_next     = byte_position + 32'd1;
    parse_phase_next       = parse_phase;
    next_chunk_offset_next = next_chunk_offset;
    header_shift_next      = header_shift;
    entries_used_next      = entries_used;
    triple_phase_next      = triple_phase;
    red_latch_next         = red_latch;
    green_latch_next       = green_latch;
    entry_counter_next     = entry_counter;
    res_a                  = '0;
    res_b                  = '0;
    extra                  = '0;
    num                    = 2'd0;

    unique case (parse_phase)
      ppe_pkg::PH_SIGNATURE: begin
        if (!sig_ok) begin
          parse_phase_next = ppe_pkg::PH_DONE;
          res_a.kind       = ppe_pkg::KIND_NOT_PNG;
          num              = 2'd1;
        end else if (byte_position == 32'(ppe_pkg::SIG_LENGTH - 1)) begin
          next_chunk_offset_next = 33'(ppe_pkg::SIG_LENGTH);
          header_shift_next      = '0;
          if (file_length < 32'(ppe_pkg::SIG_LENGTH + ppe_pkg::CHUNK_FRAME)) begin
            parse_phase_next = ppe_pkg::PH_DONE;
            res_a.kind       = ppe_pkg::KIND_NO_PALETTE;
            num              = 2'd1;
          end else begin
            parse_phase_next = ppe_pkg::PH_HEADER;
          end
        end
      end
      ppe_pkg::PH_HEADER: begin
        header_shift_next = header_shifted;
        if (header_last) begin
          if (overrun || chunk_type == ppe_pkg::TYPE_IDAT) begin
            parse_phase_next = ppe_pkg::PH_DONE;
            res_a.kind       = ppe_pkg::KIND_NO_PALETTE;
            num              = 2'd1;
          end else if (chunk_type == ppe_pkg::TYPE_PLTE) begin
            entries_used_next  = quotient;
            entry_counter_next = '0;
            triple_phase_next  = 2'd0;
            if (quotient == '0) begin
              parse_phase_next = ppe_pkg::PH_DONE;
              res_a.kind       = ppe_pkg::KIND_COMPLETE;
              num              = 2'd1;
            end else begin
              parse_phase_next = ppe_pkg::PH_PALETTE;
            end
          end else begin
            next_chunk_offset_next = body_end[32:0];
            if (skip_short) begin
              parse_phase_next = ppe_pkg::PH_DONE;
              res_a.kind       = ppe_pkg::KIND_NO_PALETTE;
              num              = 2'd1;
            end else begin
              parse_phase_next = ppe_pkg::PH_SKIP;
            end
          end
        end
      end
      ppe_pkg::PH_SKIP: begin
        if (skip_last) begin
          header_shift_next = '0;
          parse_phase_next  = ppe_pkg::PH_HEADER;
        end
      end
      ppe_pkg::PH_PALETTE: begin
        case (triple_phase)
          2'd0: begin
            red_latch_next    = data_byte;
            triple_phase_next = 2'd1;
          end
          2'd1: begin
            green_latch_next  = data_byte;
            triple_phase_next = 2'd2;
          end
          default: begin
            res_a.kind         = ppe_pkg::KIND_ENTRY;
            res_a.index        = entry_counter[7:0];
            res_a.red          = red_latch;
            res_a.green        = green_latch;
            res_a.blue         = data_byte;
            num                = 2'd1;
            entry_counter_next = counter_inc;
            triple_phase_next  = 2'd0;
            if (counter_inc >= entries_used) begin
              parse_phase_next = ppe_pkg::PH_DONE;
              res_b.kind       = ppe_pkg::KIND_COMPLETE;
              res_b.count      = entries_used;
              num              = 2'd2;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // End of file: report an undecided parse, then restart
    if (end_of_file) begin
      if (parse_phase_next != ppe_pkg::PH_DONE) begin
        extra.kind = (parse_phase_next == ppe_pkg::PH_SIGNATURE) ?
                     ppe_pkg::KIND_NOT_PNG : ppe_pkg::KIND_NO_PALETTE;
        if (num == 2'd0) begin
          res_a = extra;
        end else begin
          res_b = extra;
        end
        num = num + 2'd1;
      end
      byte_position_next     = '0;
      parse_phase_next       = ppe_pkg::PH_SIGNATURE;
      next_chunk_offset_next = 33'(ppe_pkg::SIG_LENGTH);
      header_shift_next      = '0;
      entries_used_next      = '0;
      triple_phase_next      = 2'd0;
      red_latch_next         = '0;
      green_latch_next       = '0;
      entry_counter_next     = '0;
    end

    // Mark the last result of this byte
    if (num == 2'd1) begin
      res_a.last = 1'b1;
    end else if (num == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  // Hand results to the queue only for an accepted request
  always_comb begin
    push.num    = in_fire ? num : 2'd0;
    push.first  = res_a;
    push.second = res_b;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      parse_phase       <= ppe_pkg::PH_SIGNATURE;
      next_chunk_offset <= 33'(ppe_pkg::SIG_LENGTH);
      header_shift      <= '0;
      entries_used      <= '0;
      triple_phase      <= 2'd0;
      red_latch         <= '0;
      green_latch       <= '0;
      entry_counter     <= '0;
    end else if (in_fire) begin
      byte_position     <= byte_position_next;
      parse_phase       <= parse_phase_next;
      next_chunk_offset <= next_chunk_offset_next;
      header_shift      <= header_shift_next;
      entries_used      <= entries_used_next;
      triple_phase      <= triple_phase_next;
      red_latch         <= red_latch_next;
      green_latch       <= green_latch_next;
      entry_counter     <= entry_counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_file) |=>
      (parse_phase == ppe_pkg::PH_SIGNATURE && byte_position == 32'd0))
    else $error("parse did not restart after end of file");

  a_pair_starts_with_entry: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd2) |-> (push.first.kind == ppe_pkg::KIND_ENTRY))
    else $error("two results from one byte without a palette entry first");

  a_palette_bounds: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == ppe_pkg::PH_PALETTE) |->
      (entries_used != '0 && entry_counter < entries_used))
    else $error("palette phase with no entries left");
`endif

endmodule

// File: src/ppe_result_fifo.sv
// Small result queue for the PNG palette extractor: takes up to two results a cycle.
// Depends on ppe_pkg; drives the output channel of the top level.
module ppe_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  ppe_pkg::ppe_push_t   push,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ppe_pkg::ppe_result_t head,
  output logic                 room
);

  ppe_pkg::ppe_result_t mem [ppe_pkg::FIFO_DEPTH];
  logic [ppe_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ppe_pkg::PTR_W-1:0] wr_ptr_inc;
  logic [ppe_pkg::CNT_W-1:0] count, count_next;
  logic                      pop;

  assign out_valid  = count != '0;
  assign head       = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign room       = count <= ppe_pkg::CNT_W'(ppe_pkg::FIFO_DEPTH - 2);
  assign wr_ptr_inc = wr_ptr + 1'b1;
  assign count_next = count + {{(ppe_pkg::CNT_W - 2){1'b0}}, push.num}
                      - {{(ppe_pkg::CNT_W - 1){1'b0}}, pop};

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_inc] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.num[ppe_pkg::PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= ppe_pkg::CNT_W'(ppe_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |-> room)
    else $error("results written without room in the queue");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && count == ppe_pkg::CNT_W'(1) && push.num == 2'd0) |=> !out_valid)
    else $error("queue still valid after its last result left");
`endif

endmodule

// File: src/png_palette_extractor.sv
// Top level of the PNG palette extractor: length register, parser and result queue.
// Depends on ppe_pkg, ppe_parser and ppe_result_fifo.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    data_byte, end_of_file
//   out      out_valid / out_ready  result_kind, entry_index, red, green, blue,
//                                   entry_count, last_of_run
//   cfg      cfg_valid / cfg_ready  file_length
//
// One byte is taken per cycle while in_ready is high; its zero, one or two
// results enter a four-deep queue in the same cycle and leave one per cycle
// from the queue head while out_ready is high. The input is ready while the
// queue holds two results or fewer, so a byte giving two results stalls input
// only while the output is blocked. Synchronous reset clears the parse state,
// the queue and the length register. Configuration writes are always ready.
module png_palette_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  entry_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [8:0]  entry_count,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] file_length
);

  logic [31:0]          file_length_reg;
  logic                 in_fire;
  logic                 room;
  ppe_pkg::ppe_push_t   push;
  ppe_pkg::ppe_result_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign in_fire   = in_valid && in_ready;

  // Hold the file length
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length_reg <= file_length;
    end
  end

  ppe_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .file_length (file_length_reg),
    .push        (push)
  );

  ppe_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .room      (room)
  );

  // Unpack the queue head onto the result ports
  assign result_kind = head.kind;
  assign entry_index = head.index;
  assign red         = head.red;
  assign green       = head.green;
  assign blue        = head.blue;
  assign entry_count = head.count;
  assign last_of_run = head.last;

endmodule
